// ----- hdl/mts_pkg.sv -----
// Shared types and constants for the multi-timer scheduler.
// No dependencies; imported by all modules and referenced by name in the interfaces.
package mts_pkg;

  localparam int TIMER_SLOTS  = 16;
  localparam int IDX_W        = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CLK_W        = 64;
  localparam int PERIOD_W     = 32;
  localparam int SLOT_W       = 4;
  localparam int FIRED_SLOT_W = 4;
  localparam int WAIT_W       = 16;
  localparam logic [WAIT_W-1:0] WAIT_CAP = WAIT_W'(60 * 1000);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_RESET  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_UPDATE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             latch;
    logic             clk_inc;
    logic             op_upd;
    logic             scan;
    logic [IDX_W-1:0] scan_idx;
    logic             emit;
  } cmd_t;

  typedef struct packed {
    logic in_tick;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

// ----- hdl/mts_in_if.sv -----
// Input channel interface: valid/ready handshake with one command transaction.
// Depends on mts_pkg for field widths.
interface mts_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic [mts_pkg::SLOT_W-1:0]    slot;
  logic [mts_pkg::PERIOD_W-1:0]  period_ms;
  logic                          periodic;

  modport source (output valid, output opcode, output slot, output period_ms,
                  output periodic, input ready);
  modport sink   (input valid, input opcode, input slot, input period_ms,
                  input periodic, output ready);
endinterface

// ----- hdl/mts_out_if.sv -----
// Result channel interface: valid/ready handshake with one result transaction.
// Depends on mts_pkg for field widths.
interface mts_out_if;
  logic                             valid;
  logic                             ready;
  logic                             fired;
  logic [mts_pkg::FIRED_SLOT_W-1:0] fired_slot;
  logic [mts_pkg::WAIT_W-1:0]       wait_ms;
  logic                             last;

  modport source (output valid, output fired, output fired_slot, output wait_ms,
                  output last, input ready);
  modport sink   (input valid, input fired, input fired_slot, input wait_ms,
                  input last, output ready);
endinterface

// ----- hdl/multi_timer_scheduler_unit.sv -----
// Multi-timer scheduler top level: 16 timer slots driven by a millisecond tick.
// Each input passes through update or clock tick, the 16-slot scan, then emit; a tick
// emits one result per fired slot, and no new input is accepted until the last result.
// The table scan takes one slot per cycle and also finds the earliest deadline.
// Reset (rst_n, synchronous, active low): clock to zero, all slots inactive, no result.
// Depends on mts_pkg, mts_in_if, mts_out_if, mts_ctrl and mts_dp.
module multi_timer_scheduler_unit (
  input logic       clk,
  input logic       rst_n,
  mts_in_if.sink    in_ch,
  mts_out_if.source out_ch
);
  import mts_pkg::*;

  cmd_t    cmd;
  status_t status;

  mts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  mts_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_opcode      (in_ch.opcode),
    .in_slot        (in_ch.slot),
    .in_period_ms   (in_ch.period_ms),
    .in_periodic    (in_ch.periodic),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_fired      (out_ch.fired),
    .out_fired_slot (out_ch.fired_slot),
    .out_wait_ms    (out_ch.wait_ms),
    .out_last       (out_ch.last)
  );

endmodule

// ----- hdl/mts_ctrl.sv -----
// Controller FSM: sequences accept, update or clock tick, slot scan and result emission.
// Depends on mts_pkg (state_t, cmd_t, status_t).
module mts_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mts_pkg::status_t status,
  output mts_pkg::cmd_t    cmd
);
  import mts_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cmd          = '0;
    cmd.scan_idx = idx_r;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = status.in_tick ? ST_TICK : ST_UPDATE;
        end
      end
      ST_TICK: begin
        cmd.clk_inc = 1'b1;
        idx_nxt     = '0;
        state_nxt   = ST_SCAN;
      end
      ST_UPDATE: begin
        cmd.op_upd = 1'b1;
        idx_nxt    = '0;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt = IDX_W'(idx_r + 1'b1);
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/mts_dp.sv -----
// Datapath: millisecond clock, timer slot table, wait minimum and result register.
// Depends on mts_pkg; driven by mts_ctrl through cmd_t/status_t.
module mts_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mts_pkg::cmd_t                 cmd,
  output mts_pkg::status_t              status,
  input  logic [1:0]                    in_opcode,
  input  logic [mts_pkg::SLOT_W-1:0]    in_slot,
  input  logic [mts_pkg::PERIOD_W-1:0]  in_period_ms,
  input  logic                          in_periodic,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_fired,
  output logic [mts_pkg::FIRED_SLOT_W-1:0] out_fired_slot,
  output logic [mts_pkg::WAIT_W-1:0]    out_wait_ms,
  output logic                          out_last
);
  import mts_pkg::*;

  op_t                  op_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [PERIOD_W-1:0]  pin_r;
  logic                 per_in_r;
  logic [CLK_W-1:0]     clock_r;
  logic [CLK_W-1:0]     deadline_r [TIMER_SLOTS];
  logic [PERIOD_W-1:0]  period_r   [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] periodic_r, active_r, fmask_r;
  logic [WAIT_W-1:0]    wait_r;
  logic                 out_valid_r, out_fired_r, out_last_r;
  logic [FIRED_SLOT_W-1:0] out_slot_r;
  logic [WAIT_W-1:0]    out_wait_r;

  logic [IDX_W-1:0]     rd_idx, low_idx;
  logic                 slot_ok, rd_act, rd_per, due_le, fire, act_after;
  logic [CLK_W-1:0]     rd_deadline, sum, cand;
  logic [PERIOD_W-1:0]  rd_period, add_base;
  logic [CLK_W:0]       diff;
  logic [WAIT_W-1:0]    cand_cap, wait_nxt;
  logic [TIMER_SLOTS-1:0] fmask_rest;

  assign rd_idx      = cmd.scan ? cmd.scan_idx : IDX_W'(slot_r);
  assign slot_ok     = (32'(slot_r) < TIMER_SLOTS);
  assign rd_deadline = deadline_r[rd_idx];
  assign rd_period   = period_r[rd_idx];
  assign rd_per      = periodic_r[rd_idx];
  assign rd_act      = active_r[rd_idx];

  assign add_base = (op_r == OP_ADD) ? pin_r : rd_period;
  assign sum      = clock_r + CLK_W'(add_base);
  assign diff     = {1'b0, rd_deadline} - {1'b0, clock_r};
  assign due_le   = diff[CLK_W] || (diff[CLK_W-1:0] == '0);

  assign fire      = cmd.scan && (op_r == OP_TICK) && rd_act && due_le;
  assign act_after = rd_act && !(fire && !rd_per);
  assign cand      = fire ? CLK_W'(rd_period) : (due_le ? '0 : diff[CLK_W-1:0]);
  assign cand_cap  = (cand >= CLK_W'(WAIT_CAP)) ? WAIT_CAP : cand[WAIT_W-1:0];
  assign wait_nxt  = (act_after && (cand_cap < wait_r)) ? cand_cap : wait_r;

  always_comb begin
    low_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (fmask_r[i]) low_idx = IDX_W'(i);
    end
  end
  assign fmask_rest = fmask_r & (fmask_r - TIMER_SLOTS'(1));

  assign status.in_tick   = (in_opcode == OP_TICK);
  assign status.emit_last = (fmask_rest == '0);
  assign status.out_free  = !out_valid_r || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r     <= '0;
      active_r    <= '0;
      fmask_r     <= '0;
      wait_r      <= WAIT_CAP;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.latch) wait_r <= WAIT_CAP;
      if (cmd.clk_inc) clock_r <= clock_r + CLK_W'(1);
      if (cmd.op_upd && slot_ok) begin
        case (op_r)
          OP_ADD:    active_r[rd_idx] <= 1'b1;
          OP_CANCEL: active_r[rd_idx] <= 1'b0;
          default:   ;
        endcase
      end
      if (cmd.scan) begin
        wait_r <= wait_nxt;
        if (fire) begin
          fmask_r[rd_idx] <= 1'b1;
          if (!rd_per) active_r[rd_idx] <= 1'b0;
        end
      end
      if (cmd.emit) begin
        fmask_r     <= fmask_rest;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= op_t'(in_opcode);
      slot_r   <= in_slot;
      pin_r    <= in_period_ms;
      per_in_r <= in_periodic;
    end
    if (cmd.op_upd && slot_ok) begin
      case (op_r)
        OP_ADD: begin
          period_r[rd_idx]   <= pin_r;
          periodic_r[rd_idx] <= per_in_r;
          deadline_r[rd_idx] <= sum;
        end
        OP_RESET: if (rd_act) deadline_r[rd_idx] <= sum;
        default: ;
      endcase
    end
    if (fire && rd_per) deadline_r[rd_idx] <= sum;
    if (cmd.emit) begin
      out_fired_r <= (fmask_r != '0);
      out_slot_r  <= FIRED_SLOT_W'(low_idx);
      out_wait_r  <= wait_r;
      out_last_r  <= status.emit_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fired      = out_fired_r;
  assign out_fired_slot = out_slot_r;
  assign out_wait_ms    = out_wait_r;
  assign out_last       = out_last_r;

  a_mask_clear_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |-> (fmask_r == '0))
    else $error("fired mask not empty at new transaction");

  a_wait_capped: assert property (@(posedge clk) disable iff (!rst_n)
    wait_r <= WAIT_CAP)
    else $error("wait minimum above cap");

  a_oneshot_disarm: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !rd_per) |=> !active_r[$past(rd_idx)])
    else $error("one-shot slot still active after firing");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for multi_timer_scheduler_unit: directed table, then random traffic.
// Depends on mts_pkg, mts_in_if, mts_out_if and the scheduler RTL in hdl/.
`timescale 1ns / 1ps

module testbench;
  import mts_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 320;
  localparam int IDLE_PCT     = 17;

  typedef struct packed {
    logic                    fired;
    logic [FIRED_SLOT_W-1:0] fired_slot;
    logic [WAIT_W-1:0]       wait_ms;
    logic                    last;
  } timer_report_t;

  typedef struct {
    op_t                 op;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
    logic                periodic;
    bit                  typed;
    logic                fired;
    logic [3:0]          fired_slot;
    logic [WAIT_W-1:0]   wait_ms;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  mts_in_if  in_ch ();
  mts_out_if out_ch ();

  multi_timer_scheduler_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // timer table as the scheduler should see it
  logic [CLK_W-1:0]    now_ms;
  logic [CLK_W-1:0]    due_at [TIMER_SLOTS];
  logic [PERIOD_W-1:0] reload [TIMER_SLOTS];
  logic                repeating [TIMER_SLOTS];
  logic                armed [TIMER_SLOTS];

  timer_report_t awaited_reports[$];
  int error_count    = 0;
  int sent_count     = 0;
  int reports_seen   = 0;
  int expiry_count   = 0;
  int widest_burst   = 0;
  bit calm;

  assign calm = (sent_count >= 200) && (sent_count < 260);

  function automatic void advance_timers(input op_t op, input logic [SLOT_W-1:0] s,
                                         input logic [PERIOD_W-1:0] p, input logic per,
                                         ref timer_report_t reps[$]);
    int               expired[$];
    logic [CLK_W-1:0] soonest;
    logic [CLK_W-1:0] gap;
    timer_report_t    rep;
    reps.delete();
    if (op == OP_TICK) begin
      now_ms = now_ms + 1;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        if (armed[i] && due_at[i] <= now_ms) begin
          expired.insert(expired.size(), i);
          if (repeating[i]) due_at[i] = now_ms + CLK_W'(reload[i]);
          else armed[i] = 1'b0;
        end
      end
    end else if (int'(s) < TIMER_SLOTS) begin
      case (op)
        OP_ADD: begin
          reload[s]    = p;
          repeating[s] = per;
          due_at[s]    = now_ms + CLK_W'(p);
          armed[s]     = 1'b1;
        end
        OP_RESET: begin
          if (armed[s]) due_at[s] = now_ms + CLK_W'(reload[s]);
        end
        default: armed[s] = 1'b0;
      endcase
    end
    soonest = CLK_W'(WAIT_CAP);
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (armed[i]) begin
        gap = (due_at[i] > now_ms) ? due_at[i] - now_ms : '0;
        if (gap < soonest) soonest = gap;
      end
    end
    if (expired.size() == 0) begin
      rep = '{1'b0, '0, WAIT_W'(soonest), 1'b1};
      reps.insert(reps.size(), rep);
    end else begin
      foreach (expired[k]) begin
        rep = '{1'b1, FIRED_SLOT_W'(expired[k]), WAIT_W'(soonest),
                k == expired.size() - 1};
        reps.insert(reps.size(), rep);
      end
      expiry_count += expired.size();
      if (expired.size() > widest_burst) widest_burst = expired.size();
    end
  endfunction

  // drives one command transaction; a typed row replaces the predicted report
  task automatic issue(input op_t op, input logic [SLOT_W-1:0] s,
                       input logic [PERIOD_W-1:0] p, input logic per,
                       input bit typed = 1'b0, input timer_report_t typed_rep = '0);
    timer_report_t reps[$];
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.slot      <= s;
    in_ch.period_ms <= p;
    in_ch.periodic  <= per;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
    advance_timers(op, s, p, per, reps);
    if (typed) awaited_reports.insert(awaited_reports.size(), typed_rep);
    else foreach (reps[k]) awaited_reports.insert(awaited_reports.size(), reps[k]);
  endtask

  // arm every slot with one period so a single tick can expire all of them
  task automatic arm_all(input logic [PERIOD_W-1:0] p);
    for (int i = 0; i < TIMER_SLOTS; i++)
      issue(OP_ADD, SLOT_W'(i), p, 1'($urandom_range(0, 1)));
    for (int i = 0; i < 3; i++)
      issue(OP_TICK, SLOT_W'($urandom_range(0, 15)), $urandom(), 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(0, 15))
      13:      return '0;
      14:      return '1;
      15:      return $urandom();
      10, 11, 12: return PERIOD_W'($urandom_range(0, 70000));
      default: return PERIOD_W'($urandom_range(0, 12));
    endcase
  endfunction

  stim_row_t directed_rows[] = '{
    '{OP_TICK,   4'd0,  32'd0,          1'b0, 1'b1, 1'b0, 4'd0, WAIT_CAP},
    '{OP_CANCEL, 4'd15, 32'd0,          1'b0, 1'b1, 1'b0, 4'd0, WAIT_CAP},
    '{OP_RESET,  4'd3,  32'd0,          1'b1, 1'b1, 1'b0, 4'd0, WAIT_CAP},
    '{OP_ADD,    4'd0,  32'd0,          1'b1, 1'b1, 1'b0, 4'd0, 16'd0},
    '{OP_TICK,   4'd0,  32'd0,          1'b0, 1'b1, 1'b1, 4'd0, 16'd0},
    '{OP_CANCEL, 4'd0,  32'd0,          1'b0, 1'b1, 1'b0, 4'd0, WAIT_CAP},
    '{OP_ADD,    4'd15, 32'hFFFF_FFFF,  1'b0, 1'b1, 1'b0, 4'd0, WAIT_CAP},
    '{OP_ADD,    4'd7,  32'd5,          1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
    '{OP_ADD,    4'd7,  32'd3,          1'b1, 1'b0, 1'b0, 4'd0, 16'd0},
    '{OP_TICK,   4'd0,  32'd0,          1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
    '{OP_RESET,  4'd7,  32'd0,          1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
    '{OP_TICK,   4'd0,  32'd0,          1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
    '{OP_TICK,   4'd0,  32'd0,          1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
    '{OP_TICK,   4'd0,  32'd0,          1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
    '{OP_ADD,    4'd1,  32'd60000,      1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
    '{OP_ADD,    4'd2,  32'd60001,      1'b1, 1'b0, 1'b0, 4'd0, 16'd0},
    '{OP_ADD,    4'd3,  32'd0,          1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
    '{OP_ADD,    4'd4,  32'd0,          1'b1, 1'b0, 1'b0, 4'd0, 16'd0},
    '{OP_ADD,    4'd5,  32'd1,          1'b1, 1'b0, 1'b0, 4'd0, 16'd0},
    '{OP_TICK,   4'd0,  32'd0,          1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
    '{OP_TICK,   4'd0,  32'd0,          1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
    '{OP_CANCEL, 4'd15, 32'd0,          1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
    '{OP_CANCEL, 4'd1,  32'd0,          1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
    '{OP_CANCEL, 4'd2,  32'd0,          1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
    '{OP_RESET,  4'd4,  32'd0,          1'b0, 1'b0, 1'b0, 4'd0, 16'd0}
  };

  always @(posedge clk) begin : report_check
    timer_report_t want;
    out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_reports.size() == 0) begin
        $error("unexpected report: fired=%0d fired_slot=%0d wait_ms=%0d last=%0d",
               out_ch.fired, out_ch.fired_slot, out_ch.wait_ms, out_ch.last);
        error_count++;
      end else begin
        want = awaited_reports.pop_front();
        reports_seen++;
        if (out_ch.fired !== want.fired) begin
          $error("fired: expected %0d, got %0d", want.fired, out_ch.fired);
          error_count++;
        end
        if (out_ch.fired_slot !== want.fired_slot) begin
          $error("fired_slot: expected %0d, got %0d", want.fired_slot, out_ch.fired_slot);
          error_count++;
        end
        if (out_ch.wait_ms !== want.wait_ms) begin
          $error("wait_ms: expected %0d, got %0d", want.wait_ms, out_ch.wait_ms);
          error_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d reports outstanding",
             CYCLE_LIMIT, awaited_reports.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    op_t op;
    int  pick;
    now_ms = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      armed[i]     = 1'b0;
      due_at[i]    = '0;
      reload[i]    = '0;
      repeating[i] = 1'b0;
    end
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= OP_ADD;
    in_ch.slot      <= '0;
    in_ch.period_ms <= '0;
    in_ch.periodic  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r])
      issue(directed_rows[r].op, directed_rows[r].slot, directed_rows[r].period,
            directed_rows[r].periodic, directed_rows[r].typed,
            '{directed_rows[r].fired, directed_rows[r].fired_slot,
              directed_rows[r].wait_ms, 1'b1});

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) begin
        // hold off until the scheduler has drained everything
        while (awaited_reports.size() != 0) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
        end
        arm_all(32'd2);
      end
      if (n == 280) arm_all(32'd0);
      pick = $urandom_range(0, 99);
      if (pick < 45)      op = OP_TICK;
      else if (pick < 72) op = OP_ADD;
      else if (pick < 86) op = OP_RESET;
      else                op = OP_CANCEL;
      issue(op, SLOT_W'($urandom_range(0, 15)), pick_period(), 1'($urandom_range(0, 1)));
    end
    in_ch.valid <= 1'b0;

    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d commands (ticks, adds, resets, cancels), checked %0d reports.",
             sent_count, reports_seen);
    $display("Saw %0d timer expiries, up to %0d on a single tick.",
             expiry_count, widest_burst);
    if (error_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
